FILE: rtl/fer_pkg.sv
// Shared types, codes and constants of the FAT entry read/write engine.
`timescale 1ns / 1ps

package fer_pkg;

  // Field widths of the request and result channels.
  localparam int CMD_W     = 2;
  localparam int CLUSTER_W = 28;
  localparam int ADDR_W    = 12;
  localparam int VALUE_W   = 28;
  localparam int STATUS_W  = 2;
  localparam int FS_W      = 2;
  localparam int LG_W      = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 4;

  // The sector store is split into four byte lanes so that a whole entry is reached at once.
  localparam int LANES = 4;

  // Default and limits of the sector size.
  localparam int DEFAULT_MAX_SECTOR_BYTES = 4096;
  localparam logic [LG_W-1:0] SECTOR_LG_MIN = 4'd9;
  localparam logic [LG_W-1:0] SECTOR_LG_MAX = 4'd12;

  // Nibble masks and the FAT32 entry mask.
  localparam logic [7:0]  NIB_LO        = 8'h0F;
  localparam logic [7:0]  NIB_HI        = 8'hF0;
  localparam logic [31:0] ENTRY32_MASK  = 32'h0FFF_FFFF;

  // Request commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_WR_BYTE = 2'd0,
    CMD_RD_BYTE = 2'd1,
    CMD_GET     = 2'd2,
    CMD_SET     = 2'd3
  } cmd_t;

  // Filesystem type codes.
  localparam logic [FS_W-1:0] FS_NONE  = 2'd0;
  localparam logic [FS_W-1:0] FS_FAT12 = 2'd1;
  localparam logic [FS_W-1:0] FS_FAT16 = 2'd2;
  localparam logic [FS_W-1:0] FS_FAT32 = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_TYPE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CROSS    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FS_TYPE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_LG = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the request and read the store
    logic commit;  // write the store and load the result register
  } ctl_t;

endpackage

FILE: rtl/fer_ctrl.sv
// Controller state machine of the FAT entry engine: request handshake and sequencing.
`timescale 1ns / 1ps

module fer_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output fer_pkg::ctl_t   ctl
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The result register is free when empty or being taken this cycle.
  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign ctl.load   = in_valid && (state_r == S_IDLE);
  assign ctl.commit = (state_r == S_EXEC) && out_free;
  assign out_valid  = out_valid_r;

  // Next state: IDLE reads the store; EXEC merges and writes back if output is free.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (ctl.load) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (ctl.commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The result stays valid until taken.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (ctl.commit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/fer_dpath.sv
// Datapath of the FAT entry engine: configuration, offset logic, banked sector store and merge.
`timescale 1ns / 1ps

module fer_dpath #(
  parameter int MAX_SECTOR_BYTES = fer_pkg::DEFAULT_MAX_SECTOR_BYTES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fer_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fer_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  fer_pkg::ctl_t                   ctl,
  input  logic [fer_pkg::CMD_W-1:0]       in_cmd,
  input  logic [fer_pkg::CLUSTER_W-1:0]   in_cluster,
  input  logic [fer_pkg::ADDR_W-1:0]      in_byte_addr,
  input  logic [fer_pkg::VALUE_W-1:0]     in_value,
  output logic [fer_pkg::VALUE_W-1:0]     out_read_data,
  output logic [fer_pkg::STATUS_W-1:0]    out_status
);

  // MAX_SECTOR_BYTES must be a power of two between 512 and 4096; the block does not check it.
  localparam int AW         = $clog2(MAX_SECTOR_BYTES);
  localparam int RW         = AW - 2;
  localparam int BANK_DEPTH = MAX_SECTOR_BYTES / fer_pkg::LANES;

  // Configuration registers; the sector size is kept as its effective log2.
  logic [fer_pkg::FS_W-1:0] fs_type_r, fs_type_nxt;
  logic [fer_pkg::LG_W-1:0] size_lg_r, size_lg_nxt;
  logic [fer_pkg::LG_W-1:0] lg_clamp;

  // Request decode at acceptance.
  fer_pkg::cmd_t            cmd_in;
  logic                     raw_in;
  logic [AW-1:0]            off12, off16, off32, off_sel, off_w, base;
  logic [AW:0]              size, nbytes, off_end;
  logic [AW-1:0]            size_mask;
  logic [fer_pkg::STATUS_W-1:0] status_in;
  logic [RW-1:0]            row_q [fer_pkg::LANES];

  // Captured request.
  fer_pkg::cmd_t            cmd_r;
  logic [fer_pkg::VALUE_W-1:0] value_r;
  logic [1:0]               lane_r;
  logic                     odd_r;
  logic [fer_pkg::STATUS_W-1:0] status_r;
  logic [RW-1:0]            row_r [fer_pkg::LANES];
  logic [7:0]               rd_r  [fer_pkg::LANES];

  // Execute-cycle signals.
  logic [7:0]               b   [fer_pkg::LANES];
  logic [7:0]               w   [fer_pkg::LANES];
  logic [fer_pkg::LANES-1:0] en;
  logic [7:0]               bank_wd [fer_pkg::LANES];
  logic [fer_pkg::LANES-1:0] bank_we;
  logic [fer_pkg::VALUE_W-1:0] rd_data;
  logic [31:0]              word32;
  logic                     entry_ok;

  // Result register.
  logic [fer_pkg::VALUE_W-1:0] out_read_data_r;
  logic [fer_pkg::STATUS_W-1:0] out_status_r;

  // Clamp the sector size to the legal range and to the store size.
  always_comb begin
    lg_clamp = cfg_wdata;
    if (cfg_wdata < fer_pkg::SECTOR_LG_MIN) lg_clamp = fer_pkg::SECTOR_LG_MIN;
    if (cfg_wdata > fer_pkg::SECTOR_LG_MAX) lg_clamp = fer_pkg::SECTOR_LG_MAX;
    if (lg_clamp > fer_pkg::LG_W'(AW)) lg_clamp = fer_pkg::LG_W'(AW);
  end

  // Configuration writes.
  always_comb begin
    fs_type_nxt = fs_type_r;
    size_lg_nxt = size_lg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        fer_pkg::CFG_FS_TYPE:   fs_type_nxt = cfg_wdata[fer_pkg::FS_W-1:0];
        fer_pkg::CFG_SECTOR_LG: size_lg_nxt = lg_clamp;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_type_r <= fer_pkg::FS_NONE;
      size_lg_r <= fer_pkg::SECTOR_LG_MIN;
    end else begin
      fs_type_r <= fs_type_nxt;
      size_lg_r <= size_lg_nxt;
    end
  end

  // Entry byte offset, wrapped to the sector size; only the low address bits matter.
  assign cmd_in    = fer_pkg::cmd_t'(in_cmd);
  assign raw_in    = (cmd_in == fer_pkg::CMD_WR_BYTE) || (cmd_in == fer_pkg::CMD_RD_BYTE);
  assign off12     = in_cluster[AW-1:0] + in_cluster[AW:1];
  assign off16     = {in_cluster[AW-2:0], 1'b0};
  assign off32     = {in_cluster[AW-3:0], 2'b00};
  assign size      = (AW+1)'(1) << size_lg_r;
  assign size_mask = AW'(size - (AW+1)'(1));

  always_comb begin
    unique case (fs_type_r)
      fer_pkg::FS_FAT12: off_sel = off12;
      fer_pkg::FS_FAT16: off_sel = off16;
      default:           off_sel = off32;
    endcase
    nbytes = (fs_type_r == fer_pkg::FS_FAT32) ? (AW+1)'(4) : (AW+1)'(2);
  end

  assign off_w   = off_sel & size_mask;
  assign off_end = {1'b0, off_w} + nbytes;
  assign base    = raw_in ? in_byte_addr[AW-1:0] : off_w;

  // Status of the request, settled at acceptance, before the store is written.
  always_comb begin
    priority if (raw_in)                       status_in = fer_pkg::ST_OK;
    else if (fs_type_r == fer_pkg::FS_NONE)    status_in = fer_pkg::ST_BAD_TYPE;
    else if (off_end > size)                   status_in = fer_pkg::ST_CROSS;
    else                                       status_in = fer_pkg::ST_OK;
  end

  // Row per lane: lanes below the start lane hold bytes of the next row.
  for (genvar k = 0; k < fer_pkg::LANES; k++) begin : g_row
    logic lt;
    assign lt       = (2'(k) < base[1:0]);
    assign row_q[k] = base[AW-1:2] + {{(RW-1){1'b0}}, lt};
  end

  // Capture the request.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r    <= cmd_in;
      value_r  <= in_value;
      lane_r   <= base[1:0];
      odd_r    <= in_cluster[0];
      status_r <= status_in;
      row_r    <= row_q;
    end
  end

  // Byte lanes of the sector store: read at acceptance, written at commit.
  for (genvar k = 0; k < fer_pkg::LANES; k++) begin : g_bank
    logic [7:0] mem [BANK_DEPTH];
    always_ff @(posedge clk) begin
      if (ctl.commit && bank_we[k]) mem[row_r[k]] <= bank_wd[k];
      if (ctl.load) rd_r[k] <= mem[row_q[k]];
    end
  end

  // Put the read bytes in entry order.
  always_comb begin
    for (int i = 0; i < fer_pkg::LANES; i++) begin
      b[i] = rd_r[lane_r + 2'(i)];
    end
  end

  assign entry_ok = (status_r == fer_pkg::ST_OK);
  assign word32   = {b[3], b[2], b[1], b[0]} & fer_pkg::ENTRY32_MASK;

  // Read data: raw byte or entry, zero for writes and failed requests.
  always_comb begin
    rd_data = '0;
    if (cmd_r == fer_pkg::CMD_RD_BYTE) begin
      rd_data = {20'd0, b[0]};
    end else if (cmd_r == fer_pkg::CMD_GET && entry_ok) begin
      unique case (fs_type_r)
        fer_pkg::FS_FAT12: rd_data = odd_r ? {16'd0, b[1], b[0][7:4]}
                                           : {16'd0, b[1][3:0], b[0]};
        fer_pkg::FS_FAT16: rd_data = {12'd0, b[1], b[0]};
        default:           rd_data = word32[fer_pkg::VALUE_W-1:0];
      endcase
    end
  end

  // New bytes of a write, with the nibble merges of FAT12 and the FAT32 reserved bits.
  always_comb begin
    w[0] = value_r[7:0];
    w[1] = value_r[15:8];
    w[2] = value_r[23:16];
    w[3] = (b[3] & fer_pkg::NIB_HI) | {4'd0, value_r[27:24]};
    en   = '0;
    if (cmd_r == fer_pkg::CMD_WR_BYTE) begin
      en = 4'b0001;
    end else if (cmd_r == fer_pkg::CMD_SET && entry_ok) begin
      unique case (fs_type_r)
        fer_pkg::FS_FAT12: begin
          en = 4'b0011;
          if (odd_r) begin
            w[0] = (b[0] & fer_pkg::NIB_LO) | {value_r[3:0], 4'd0};
            w[1] = value_r[11:4];
          end else begin
            w[1] = (b[1] & fer_pkg::NIB_HI) | {4'd0, value_r[11:8]};
          end
        end
        fer_pkg::FS_FAT16: en = 4'b0011;
        default:           en = 4'b1111;
      endcase
    end
  end

  // Route entry bytes back to their lanes.
  always_comb begin
    for (int k = 0; k < fer_pkg::LANES; k++) begin
      bank_wd[k] = w[2'(k) - lane_r];
      bank_we[k] = en[2'(k) - lane_r];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_read_data_r <= rd_data;
      out_status_r    <= status_r;
    end
  end

  assign out_read_data = out_read_data_r;
  assign out_status    = out_status_r;

endmodule

FILE: rtl/fat_entry_read_write_engine_core.sv
// Each request is accepted in IDLE, where the byte-lane store is read, and is merged,
// written back and registered as a result in EXEC once the result register is free.
// A new request is accepted only after the previous one has been written back.
// A waiting result does not block acceptance of the next request.
// Reset (synchronous, active low) clears control, fs_type (none) and sector size (512 bytes);
// the sector store is not cleared and holds undefined data until written.
`timescale 1ns / 1ps

module fat_entry_read_write_engine_core #(
  parameter int MAX_SECTOR_BYTES = fer_pkg::DEFAULT_MAX_SECTOR_BYTES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fer_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fer_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fer_pkg::CMD_W-1:0]       in_cmd,
  input  logic [fer_pkg::CLUSTER_W-1:0]   in_cluster,
  input  logic [fer_pkg::ADDR_W-1:0]      in_byte_addr,
  input  logic [fer_pkg::VALUE_W-1:0]     in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fer_pkg::VALUE_W-1:0]     out_read_data,
  output logic [fer_pkg::STATUS_W-1:0]    out_status
);

  fer_pkg::ctl_t ctl;

  // Sequencing of each request.
  fer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  // Store, offset arithmetic and result register.
  fer_dpath #(
    .MAX_SECTOR_BYTES (MAX_SECTOR_BYTES)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .ctl           (ctl),
    .in_cmd        (in_cmd),
    .in_cluster    (in_cluster),
    .in_byte_addr  (in_byte_addr),
    .in_value      (in_value),
    .out_read_data (out_read_data),
    .out_status    (out_status)
  );

  // A request is never captured in the cycle in which another is committed.
  a_load_commit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.load && ctl.commit))
    else $error("load and commit in the same cycle");

  // Once a request is captured, the input side stalls while it executes.
  a_load_then_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> in_stall)
    else $error("input not stalled after capture");

  // A commit always presents a result.
  a_commit_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |=> out_valid)
    else $error("no result after commit");

  // A taken result with nothing new behind it leaves the output empty.
  a_taken_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !ctl.commit) |=> !out_valid)
    else $error("result repeated after being taken");

endmodule
